/* hdl/rtq_pkg.sv */
package rtq_pkg;

    // default sizes
    localparam int TIMER_SLOTS_DEF    = 16;
    localparam int FIRES_PER_TICK_DEF = 16;

    // stream widths
    localparam int TIME_W     = 32;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = 66;

    // requested operation
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    // result kinds
    typedef enum logic [2:0] {
        KIND_INSERTED = 3'd0,
        KIND_ERASED   = 3'd1,
        KIND_LEFT     = 3'd2,
        KIND_FIRED    = 3'd3,
        KIND_DONE     = 3'd4
    } t_kind;

    // result status
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_FIRE,
        ST_EMIT
    } t_state;

    // one timer slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] id;
    } t_slot;

    // one result item
    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [TIME_W-1:0] id;
        logic [TIME_W-1:0] left;
        logic              last;
    } t_result;

    // operands of the shared arithmetic unit
    typedef struct packed {
        logic [TIME_W-1:0] a_hi;
        logic [TIME_W-1:0] a_lo;
        logic [TIME_W-1:0] b_hi;
        logic [TIME_W-1:0] b_lo;
    } t_alu_in;

    // results of the shared arithmetic unit
    typedef struct packed {
        logic              key_lt;
        logic              lo_eq;
        logic [TIME_W-1:0] sub_floor;
        logic [TIME_W-1:0] add_sat;
    } t_alu_out;

endpackage

/* hdl/rtq_slot_mem.sv */
module rtq_slot_mem
    import rtq_pkg::*;
#(
    parameter int DEPTH = TIMER_SLOTS_DEF,
    parameter int IW    = $clog2(TIMER_SLOTS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rtq_alu.sv */
module rtq_alu
    import rtq_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [TIME_W:0] w_sum;
    logic            w_hi_lt;
    logic            w_hi_eq;

    // key compare: high word first, low word breaks ties
    assign w_hi_lt = i_op.a_hi < i_op.b_hi;
    assign w_hi_eq = i_op.a_hi == i_op.b_hi;
    assign o_res.key_lt = w_hi_lt || (w_hi_eq && (i_op.a_lo < i_op.b_lo));
    assign o_res.lo_eq  = i_op.a_lo == i_op.b_lo;

    // time left, floored at zero
    assign o_res.sub_floor = (i_op.b_hi < i_op.a_hi) ? (i_op.a_hi - i_op.b_hi) : '0;

    // next expiry, saturating
    assign w_sum = {1'b0, i_op.a_hi} + {1'b0, i_op.b_lo};
    assign o_res.add_sat = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];

endmodule

/* hdl/repeating_timer_queue.sv */
// Tick: the slots are scanned again for each fired timer and once more for the done item.
// Throughput: one item at a time; each pass walks the slots one per cycle through the
// single read port of the slot memory and one shared compare/add unit.
// Reset (synchronous, active low) clears valid bits, id counter, sequencer and output
// register; the slot memory itself is not cleared.
module repeating_timer_queue
    import rtq_pkg::*;
#(
    parameter int TIMER_SLOTS    = TIMER_SLOTS_DEF,
    parameter int FIRES_PER_TICK = FIRES_PER_TICK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_time, repeat_ms, timer_id, now_ms
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, result_id, left_ms, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic [2:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int NW = $clog2(FIRES_PER_TICK + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TIMER_SLOTS);
    localparam logic [NW-1:0] FIRE_MAX = NW'(FIRES_PER_TICK);

    t_state r_state, n_state;

    // control registers
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [TIME_W-1:0]      r_idc, n_idc;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic                   r_best_vld, n_best_vld;
    logic [NW-1:0]          r_n, n_n;
    logic                   r_m_valid, n_m_valid;

    // payload registers
    t_action           r_act, n_act;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_rep, n_rep;
    logic [TIME_W-1:0] r_tid, n_tid;
    logic [TIME_W-1:0] r_now, n_now;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic [TIME_W-1:0] r_best_exp, n_best_exp;
    logic [TIME_W-1:0] r_best_id, n_best_id;
    logic [TIME_W-1:0] r_best_int, n_best_int;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    t_result           r_res, n_res;
    t_result           r_m_res, n_m_res;

    // memory and unit hookup
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_slot         w_wdata;
    t_slot         w_rd;
    t_alu_in       w_op;
    t_alu_out      w_alu;

    // decisions
    logic          w_accept;
    logic          w_find;
    logic [IW-1:0] w_cidx;
    logic          w_issue;
    logic          w_slot_vld;
    logic          w_hit;
    logic          w_scan_end;
    logic          w_better;
    logic          w_free;
    logic          w_full;
    logic          w_fire;
    logic          w_emit;
    logic [TIME_W-1:0] w_new_id;
    t_kind         w_find_kind;

    rtq_slot_mem #(
        .DEPTH (TIMER_SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_cidx),
        .o_rdata (w_rd)
    );

    rtq_alu u_alu (
        .i_op  (w_op),
        .o_res (w_alu)
    );

    // operand selection for the shared unit
    always_comb begin
        w_op.a_hi = (r_state == ST_FIRE) ? r_best_exp : w_rd.expiry;
        w_op.a_lo = w_rd.id;
        w_op.b_hi = ((r_state == ST_FIRE) || w_find) ? r_now : r_best_exp;
        if (r_state == ST_FIRE) begin
            w_op.b_lo = r_best_int;
        end else if (w_find) begin
            w_op.b_lo = r_tid;
        end else begin
            w_op.b_lo = r_best_id;
        end
    end

    // scan decisions
    assign w_accept    = s_tvalid && s_tready;
    assign w_find      = (r_act == ACT_ERASE) || (r_act == ACT_QUERY);
    assign w_cidx      = r_cnt[IW-1:0];
    assign w_issue     = (r_state == ST_SCAN) && (r_cnt != CNT_END);
    assign w_slot_vld  = r_valid[r_pidx];
    assign w_hit       = (r_state == ST_SCAN) && r_pend && w_find && w_slot_vld && w_alu.lo_eq;
    assign w_scan_end  = (r_state == ST_SCAN) && r_pend && (r_pidx == LAST_IDX);
    assign w_better    = (r_state == ST_SCAN) && r_pend && !w_find && w_slot_vld
                         && (!r_best_vld || w_alu.key_lt);
    assign w_free      = (r_state == ST_FREE) && !r_valid[w_cidx];
    assign w_full      = (r_state == ST_FREE) && r_valid[w_cidx] && (w_cidx == LAST_IDX);
    assign w_fire      = (r_state == ST_FIRE) && r_best_vld && (w_alu.sub_floor == '0)
                         && (r_n != FIRE_MAX);
    assign w_emit      = (r_state == ST_EMIT) && (!r_m_valid || m_tready);
    assign w_new_id    = ((r_idc + 1'b1) == '0) ? TIME_W'(1) : (r_idc + 1'b1);
    assign w_find_kind = (r_act == ACT_ERASE) ? KIND_ERASED : KIND_LEFT;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (t_action'(s_tuser) == ACT_INSERT) ? ST_FREE : ST_SCAN;
                end
            end
            ST_FREE: begin
                if (w_free || w_full) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (w_find && (w_hit || w_scan_end)) begin
                    n_state = ST_EMIT;
                end else if (!w_find && w_scan_end) begin
                    n_state = ST_FIRE;
                end
            end
            ST_FIRE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = r_res.last ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid    = r_valid;
        n_idc      = r_idc;
        n_cnt      = r_cnt;
        n_pend     = 1'b0;
        n_best_vld = r_best_vld;
        n_n        = r_n;
        n_act      = r_act;
        n_start    = r_start;
        n_rep      = r_rep;
        n_tid      = r_tid;
        n_now      = r_now;
        n_pidx     = w_cidx;
        n_best_exp = r_best_exp;
        n_best_id  = r_best_id;
        n_best_int = r_best_int;
        n_best_idx = r_best_idx;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = w_cidx;
        w_wdata    = '{expiry: r_start, interval: r_rep, id: w_new_id};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_act      = t_action'(s_tuser);
                    n_start    = s_tdata[31:0];
                    n_rep      = s_tdata[63:32];
                    n_tid      = s_tdata[95:64];
                    n_now      = s_tdata[127:96];
                    n_cnt      = '0;
                    n_best_vld = 1'b0;
                    n_n        = '0;
                end
            end
            ST_FREE: begin
                if (w_free) begin
                    w_we            = 1'b1;
                    n_valid[w_cidx] = 1'b1;
                    n_idc           = w_new_id;
                    n_res = '{kind: KIND_INSERTED, status: STAT_OK, id: w_new_id,
                              left: '0, last: 1'b1};
                end else if (w_full) begin
                    n_res = '{kind: KIND_INSERTED, status: STAT_FULL, id: '0,
                              left: '0, last: 1'b1};
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SCAN: begin
                // issue one slot read per cycle
                n_pend = w_issue;
                if (w_issue) begin
                    n_cnt = r_cnt + 1'b1;
                end
                // find by id: lowest matching slot
                if (w_hit) begin
                    if (r_act == ACT_ERASE) begin
                        n_valid[r_pidx] = 1'b0;
                    end
                    n_res = '{kind: w_find_kind, status: STAT_OK, id: r_tid,
                              left: (r_act == ACT_QUERY) ? w_alu.sub_floor : '0,
                              last: 1'b1};
                end else if (w_find && w_scan_end) begin
                    n_res = '{kind: w_find_kind, status: STAT_NOT_FOUND, id: r_tid,
                              left: '0, last: 1'b1};
                end
                // earliest expiry, lowest id on ties
                if (w_better) begin
                    n_best_vld = 1'b1;
                    n_best_exp = w_rd.expiry;
                    n_best_id  = w_rd.id;
                    n_best_int = w_rd.interval;
                    n_best_idx = r_pidx;
                end
            end
            ST_FIRE: begin
                if (w_fire) begin
                    n_n = r_n + 1'b1;
                    if (r_best_int != '0) begin
                        w_we    = 1'b1;
                        w_waddr = r_best_idx;
                        w_wdata = '{expiry: w_alu.add_sat, interval: r_best_int,
                                    id: r_best_id};
                    end else begin
                        n_valid[r_best_idx] = 1'b0;
                    end
                    n_res = '{kind: KIND_FIRED, status: STAT_OK, id: r_best_id,
                              left: '0, last: 1'b0};
                end else begin
                    n_res = '{kind: KIND_DONE, status: STAT_OK, id: r_tid,
                              left: '0, last: 1'b1};
                end
            end
            ST_EMIT: begin
                // restart the scan for the next fire of this tick
                if (w_emit && !r_res.last) begin
                    n_cnt      = '0;
                    n_best_vld = 1'b0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // output register
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        if (w_emit) begin
            n_m_valid = 1'b1;
            n_m_res   = r_res;
        end else if (m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_idc      <= '0;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
            r_best_vld <= 1'b0;
            r_n        <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_idc      <= n_idc;
            r_cnt      <= n_cnt;
            r_pend     <= n_pend;
            r_best_vld <= n_best_vld;
            r_n        <= n_n;
            r_m_valid  <= n_m_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_start    <= n_start;
        r_rep      <= n_rep;
        r_tid      <= n_tid;
        r_now      <= n_now;
        r_pidx     <= n_pidx;
        r_best_exp <= n_best_exp;
        r_best_id  <= n_best_id;
        r_best_int <= n_best_int;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
        r_m_res    <= n_m_res;
    end

    // ports
    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, r_m_res.left, r_m_res.id,
                       r_m_res.status};
    assign m_tuser  = r_m_res.kind;
    assign m_tlast  = r_m_res.last;

endmodule

/* hdl/rtq_checker.sv */
module rtq_checker
    import rtq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]            m_tuser,
    input logic                  m_tlast
);

    // busy right after taking an item
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input taken again in the cycle after an accept");

    // only the final result of an item may wait while idle
    a_idle_holds_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_tready && m_tvalid) |-> m_tlast
    ) else $error("idle while a non-final result is pending");

    // fired items are never final, all other kinds are
    a_last_matches_kind: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_FIRED))
    ) else $error("tlast does not agree with result kind");

    // stalled result holds
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast))
    ) else $error("stalled result changed");

endmodule

bind repeating_timer_queue rtq_checker u_rtq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* verif/tb_repeating_timer_queue.sv */
module tb_repeating_timer_queue;
    import rtq_pkg::*;

    localparam int SLOTS      = TIMER_SLOTS_DEF;
    localparam int FIRE_LIMIT = FIRES_PER_TICK_DEF;
    localparam int RAND_OPS   = 435;

    // one request as offered on the input stream
    typedef struct {
        t_action     action;
        logic [31:0] start;
        logic [31:0] period;
        logic [31:0] tid;
        logic [31:0] now;
        bit          drain;
    } t_timer_op;

    // one predicted result item
    typedef struct {
        t_kind       kind;
        t_status     status;
        logic [31:0] rid;
        logic [31:0] left;
        logic        last;
    } t_timer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // start_time, repeat_ms, timer_id, now_ms
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // action
    logic [1:0]            s_tuser = 2'd0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // status, result_id, left_ms, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;
    // kind
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    // shadow timer table
    bit          tmr_valid [SLOTS];
    logic [31:0] tmr_expiry [SLOTS];
    logic [31:0] tmr_period [SLOTS];
    logic [31:0] tmr_id [SLOTS];
    logic [31:0] last_issued_id;

    t_timer_op     pending_ops[$];
    t_timer_result expected_results[$];
    t_timer_op     offered_op;
    t_timer_result oldest;
    int            items_sent = 0;
    int            results_seen = 0;
    int            n_fail = 0;
    int            hold_left = 0;

    repeating_timer_queue #(
        .TIMER_SLOTS    (SLOTS),
        .FIRES_PER_TICK (FIRE_LIMIT)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow table and queue the results it causes
    function automatic void apply_timer_op(input t_timer_op op);
        int          slot;
        int          fired;
        logic [32:0] sum;
        slot = -1;
        case (op.action)
            ACT_INSERT: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tmr_valid[i])
                        slot = i;
                if (slot < 0) begin
                    expected_results.push_back('{KIND_INSERTED, STAT_FULL, 32'd0, 32'd0, 1'b1});
                end else begin
                    last_issued_id = last_issued_id + 32'd1;
                    if (last_issued_id == 32'd0)
                        last_issued_id = 32'd1;
                    tmr_valid[slot]  = 1'b1;
                    tmr_expiry[slot] = op.start;
                    tmr_period[slot] = op.period;
                    tmr_id[slot]     = last_issued_id;
                    expected_results.push_back('{KIND_INSERTED, STAT_OK, last_issued_id,
                                                 32'd0, 1'b1});
                end
            end
            ACT_ERASE, ACT_QUERY: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tmr_valid[i] && tmr_id[i] == op.tid)
                        slot = i;
                if (slot < 0) begin
                    expected_results.push_back('{(op.action == ACT_ERASE) ? KIND_ERASED : KIND_LEFT,
                                                 STAT_NOT_FOUND, op.tid, 32'd0, 1'b1});
                end else if (op.action == ACT_ERASE) begin
                    tmr_valid[slot] = 1'b0;
                    expected_results.push_back('{KIND_ERASED, STAT_OK, op.tid, 32'd0, 1'b1});
                end else begin
                    expected_results.push_back('{KIND_LEFT, STAT_OK, op.tid,
                        (tmr_expiry[slot] > op.now) ? tmr_expiry[slot] - op.now : 32'd0, 1'b1});
                end
            end
            default: begin
                fired = 0;
                while (fired < FIRE_LIMIT) begin
                    // earliest expiry, ties to the lowest id
                    slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (tmr_valid[i] && (slot < 0 || tmr_expiry[i] < tmr_expiry[slot] ||
                            (tmr_expiry[i] == tmr_expiry[slot] && tmr_id[i] < tmr_id[slot])))
                            slot = i;
                    if (slot < 0 || tmr_expiry[slot] > op.now)
                        break;
                    expected_results.push_back('{KIND_FIRED, STAT_OK, tmr_id[slot], 32'd0, 1'b0});
                    fired++;
                    if (tmr_period[slot] != 32'd0) begin
                        sum = {1'b0, tmr_expiry[slot]} + {1'b0, tmr_period[slot]};
                        tmr_expiry[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end else begin
                        tmr_valid[slot] = 1'b0;
                    end
                end
                expected_results.push_back('{KIND_DONE, STAT_OK, op.tid, 32'd0, 1'b1});
            end
        endcase
    endfunction

    task automatic add_op(input t_action action, input logic [31:0] start,
                          input logic [31:0] period, input logic [31:0] tid,
                          input logic [31:0] now, input bit drain);
        pending_ops.push_back('{action, start, period, tid, now, drain});
    endtask

    // input side: offer queued items, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_timer_op(offered_op);
                items_sent = items_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 &&
                    !(pending_ops[0].drain && expected_results.size() != 0) &&
                    ((items_sent >= 220 && items_sent < 300) || $urandom_range(0, 99) >= 19)) begin
                    offered_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_op.now, offered_op.tid, offered_op.period,
                                 offered_op.start};
                    s_tuser  <= offered_op.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected item: kind %0d id %0d", m_tuser, m_tdata[33:2]);
                    n_fail++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_tuser !== oldest.kind) begin
                        $error("kind: expected %0d, got %0d", oldest.kind, m_tuser);
                        n_fail++;
                    end
                    if (m_tdata[1:0] !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, m_tdata[1:0]);
                        n_fail++;
                    end
                    if (m_tdata[33:2] !== oldest.rid) begin
                        $error("result_id: expected %0d, got %0d", oldest.rid, m_tdata[33:2]);
                        n_fail++;
                    end
                    if (m_tdata[65:34] !== oldest.left) begin
                        $error("left_ms: expected %0d, got %0d", oldest.left, m_tdata[65:34]);
                        n_fail++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $error("last: expected %0d, got %0d", oldest.last, m_tlast);
                        n_fail++;
                    end
                end
                results_seen = results_seen + 1;
            end
            // long hold-off so the block backs up onto its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready && (results_seen == 80 || results_seen == 400)) begin
                hold_left <= 300;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= (results_seen >= 250 && results_seen < 330) ||
                            $urandom_range(0, 99) >= 19;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [31:0] now_cur;
        logic [31:0] pick;
        int          ids_handed;
        int          sel;
        int          r;
        last_issued_id = 32'd0;
        for (int i = 0; i < SLOTS; i++)
            tmr_valid[i] = 1'b0;

        // directed: absent ids, saturation, time passed, full table, fire limit
        add_op(ACT_QUERY,  $urandom, $urandom, 32'd1, 32'd0, 1'b0);
        add_op(ACT_ERASE,  $urandom, $urandom, 32'd0, $urandom, 1'b0);
        add_op(ACT_INSERT, 32'd7, 32'hFFFF_FFFF, $urandom, $urandom, 1'b0);
        add_op(ACT_INSERT, 32'd0, 32'd0, $urandom, $urandom, 1'b0);
        add_op(ACT_QUERY,  $urandom, $urandom, 32'd1, 32'd5, 1'b0);
        add_op(ACT_QUERY,  $urandom, $urandom, 32'd2, 32'd5, 1'b0);
        add_op(ACT_TICK,   $urandom, $urandom, 32'h0000_005A, 32'd10, 1'b0);
        for (int k = 0; k < SLOTS; k++)
            add_op(ACT_INSERT, 32'd50, k % 3, $urandom, $urandom, 1'b0);
        add_op(ACT_TICK,   32'd0, 32'd0, 32'hFFFF_FFFF, 32'd200, 1'b0);
        add_op(ACT_ERASE,  $urandom, $urandom, 32'd1, $urandom, 1'b0);
        ids_handed = 17;

        // random: times move forward in a window so ticks keep firing
        now_cur = 32'd1000;
        for (int k = 0; k < RAND_OPS; k++) begin
            sel = $urandom_range(0, 99);
            r   = $urandom_range(0, 99);
            pick = (r < 6) ? $urandom : $urandom_range(0, ids_handed + 1);
            if (sel < 35) begin
                ids_handed++;
                add_op(ACT_INSERT,
                       (r < 5) ? $urandom : now_cur + $urandom_range(0, 300),
                       (r < 55) ? 32'd0 : (r < 90) ? $urandom_range(1, 120) : $urandom,
                       $urandom, $urandom, k == 0 || k == 150);
            end else if (sel < 55) begin
                add_op(ACT_ERASE, $urandom, $urandom, pick, $urandom, k == 0 || k == 150);
            end else if (sel < 75) begin
                add_op(ACT_QUERY, $urandom, $urandom, pick,
                       (r < 5) ? $urandom : now_cur + $urandom_range(0, 40),
                       k == 0 || k == 150);
            end else begin
                now_cur = now_cur + $urandom_range(0, 80);
                add_op(ACT_TICK, $urandom, $urandom, $urandom,
                       (r < 3) ? $urandom : now_cur, k == 0 || k == 150);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * SLOTS + 20) @(posedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
